[sv/ptw_pkg.sv]
// Shared constants, item types and codes of the page table walker.
package ptw_pkg;

	localparam int TABLE_PAGES      = 64;
	localparam int ENTRIES_PER_PAGE = 512;
	localparam int MAX_MAP_PAGES    = 1023;

	localparam int IDX_W   = $clog2(ENTRIES_PER_PAGE);
	localparam int PAGE_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int NFP_W   = $clog2(TABLE_PAGES + 1);
	localparam int DEPTH   = TABLE_PAGES * ENTRIES_PER_PAGE;
	localparam int ADDR_W  = PAGE_W + IDX_W;
	localparam int ENTRY_W = 64;
	localparam int PPN_W   = 44;
	localparam int VA_W    = 39;
	localparam int PA_W    = 56;
	localparam int VPN_W   = VA_W - 12;
	localparam int COUNT_W = 10;
	localparam int PERM_W  = 8;
	localparam int STAT_W  = 3;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic [PADDR_W-4:0] REG_TABLE_BASE = '0;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_MAP    = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMAP    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOPAGES  = 3'd4;

	typedef struct packed {
		logic               operation;
		logic [VA_W-1:0]    virt_addr;
		logic [PA_W-1:0]    phys_addr;
		logic [COUNT_W-1:0] page_count;
		logic [PERM_W-1:0]  perm;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ENTRY_W-1:0] leaf_entry;
		logic [COUNT_W-1:0] pages_mapped;
	} out_item_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

endpackage

[sv/ptw_ram.sv]
// Generic single-port RAM with registered read data.
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[sv/ptw_alu.sv]
// Shared 44-bit adder and subtractor used by the evaluate, allocate, leaf and next steps of the walk.
module ptw_alu (
	input  logic [ptw_pkg::PPN_W-1:0] a,
	input  logic [ptw_pkg::PPN_W-1:0] b,
	input  logic                      sub,
	output logic [ptw_pkg::PPN_W-1:0] y
);

	assign y = sub ? (a - b) : (a + b);

endmodule

[sv/ptw_seq.sv]
// Sequencer that clears, walks, allocates and fills the table store one step at a time.
module ptw_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ptw_pkg::PPN_W-1:0] base,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ptw_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ptw_pkg::out_item_t        out_data,
	output ptw_pkg::mem_req_t         mem_req,
	input  logic [ptw_pkg::ENTRY_W-1:0] mem_rdata
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_START = 4'd2;
	localparam logic [3:0] S_READ  = 4'd3;
	localparam logic [3:0] S_EVAL  = 4'd4;
	localparam logic [3:0] S_ALLOC = 4'd5;
	localparam logic [3:0] S_LEAF  = 4'd6;
	localparam logic [3:0] S_NEXT  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]                        state_q;
	logic [ptw_pkg::ADDR_W-1:0]        clr_q;
	logic                              op_q;
	logic [ptw_pkg::VPN_W-1:0]         vpn_q;
	logic [ptw_pkg::PPN_W-1:0]         ppn_q;
	logic [ptw_pkg::COUNT_W-1:0]       count_q;
	logic [ptw_pkg::PERM_W-1:0]        perm_q;
	logic [1:0]                        level_q;
	logic [ptw_pkg::PAGE_W-1:0]        page_q;
	logic [ptw_pkg::NFP_W-1:0]         nfp_q;
	logic [ptw_pkg::STAT_W-1:0]        status_q;
	logic [ptw_pkg::ENTRY_W-1:0]       leaf_q;
	logic [ptw_pkg::COUNT_W-1:0]       mapped_q;
	logic [ptw_pkg::ADDR_W-1:0]        slot_q;
	ptw_pkg::out_item_t                out_q;
	logic                              out_valid_q;

	logic [ptw_pkg::IDX_W-1:0]         idx;
	logic [ptw_pkg::PPN_W-1:0]         alu_a;
	logic [ptw_pkg::PPN_W-1:0]         alu_b;
	logic                              alu_sub;
	logic [ptw_pkg::PPN_W-1:0]         alu_y;
	logic [ptw_pkg::ENTRY_W-1:0]       leaf_e;
	logic [ptw_pkg::COUNT_W-1:0]       mapped_inc;

	ptw_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	always_comb begin
		case (level_q)
			2'd2: idx = vpn_q[3*ptw_pkg::IDX_W-1:2*ptw_pkg::IDX_W];
			2'd1: idx = vpn_q[2*ptw_pkg::IDX_W-1:ptw_pkg::IDX_W];
			default: idx = vpn_q[ptw_pkg::IDX_W-1:0];
		endcase
	end

	assign leaf_e = {10'b0, ppn_q, 2'b0, perm_q[ptw_pkg::PERM_W-1:1], 1'b1};
	assign mapped_inc = mapped_q + 1'b1;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_EVAL: begin
				alu_a   = mem_rdata[10 +: ptw_pkg::PPN_W];
				alu_b   = base;
				alu_sub = 1'b1;
			end
			S_ALLOC: begin
				alu_a = base;
				alu_b = ptw_pkg::PPN_W'(nfp_q);
			end
			S_LEAF: begin
				alu_a = ppn_q;
				alu_b = ptw_pkg::PPN_W'(1);
			end
			S_NEXT: begin
				alu_a = ptw_pkg::PPN_W'(vpn_q);
				alu_b = ptw_pkg::PPN_W'(1);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = slot_q;
		mem_req.wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			S_READ: begin
				mem_req.addr = {page_q, idx};
			end
			S_ALLOC: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {10'b0, alu_y, 9'b0, 1'b1};
			end
			S_LEAF: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = leaf_e;
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			nfp_q       <= ptw_pkg::NFP_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ptw_pkg::ADDR_W'(ptw_pkg::DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_data.operation;
						vpn_q    <= in_data.virt_addr[ptw_pkg::VA_W-1:12];
						ppn_q    <= in_data.phys_addr[ptw_pkg::PA_W-1:12];
						count_q  <= in_data.page_count;
						perm_q   <= in_data.perm;
						leaf_q   <= '0;
						mapped_q <= '0;
						if (in_data.operation == ptw_pkg::OP_MAP &&
							(in_data.page_count == '0 ||
							32'(in_data.page_count) > ptw_pkg::MAX_MAP_PAGES)) begin
							status_q <= ptw_pkg::ST_RANGE;
							state_q  <= S_DONE;
						end else begin
							status_q <= ptw_pkg::ST_OK;
							state_q  <= S_START;
						end
					end
				end
				S_START: begin
					if (vpn_q[ptw_pkg::VPN_W-1]) begin
						status_q <= ptw_pkg::ST_RANGE;
						state_q  <= S_DONE;
					end else begin
						level_q <= 2'd2;
						page_q  <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					slot_q  <= {page_q, idx};
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (level_q == 2'd0) begin
						if (op_q == ptw_pkg::OP_LOOKUP) begin
							leaf_q  <= mem_rdata;
							state_q <= S_DONE;
						end else if (mem_rdata[0]) begin
							status_q <= ptw_pkg::ST_REMAP;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_LEAF;
						end
					end else if (mem_rdata[0]) begin
						if (alu_y < ptw_pkg::PPN_W'(nfp_q)) begin
							page_q  <= alu_y[ptw_pkg::PAGE_W-1:0];
							level_q <= level_q - 1'b1;
							state_q <= S_READ;
						end else begin
							status_q <= ptw_pkg::ST_NOTFOUND;
							state_q  <= S_DONE;
						end
					end else if (op_q == ptw_pkg::OP_LOOKUP) begin
						status_q <= ptw_pkg::ST_NOTFOUND;
						state_q  <= S_DONE;
					end else if (nfp_q == ptw_pkg::NFP_W'(ptw_pkg::TABLE_PAGES)) begin
						status_q <= ptw_pkg::ST_NOPAGES;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					page_q  <= nfp_q[ptw_pkg::PAGE_W-1:0];
					nfp_q   <= nfp_q + 1'b1;
					level_q <= level_q - 1'b1;
					state_q <= S_READ;
				end
				S_LEAF: begin
					leaf_q   <= leaf_e;
					mapped_q <= mapped_inc;
					ppn_q    <= alu_y;
					if (mapped_inc == count_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					vpn_q   <= alu_y[ptw_pkg::VPN_W-1:0];
					state_q <= S_START;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.status       <= status_q;
						out_q.leaf_entry   <= leaf_q;
						out_q.pages_mapped <= mapped_q;
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/three_level_page_table_walker.sv]
// Top level of the three-level page table walker with its register port.
//
// An input item on in_valid/in_ready asks for a lookup or for a map of a
// run of pages; every item gives exactly one result item on
// out_valid/out_ready with a status, a leaf entry and a page count.
// The table base register is written through the APB port at addresses 0 to 7.
// A lookup walks the three levels, each with a read step and an evaluate
// step of the single-port table store, with a start step before the walk
// and a done step that loads the result. A map walks every page this way,
// adds a leaf step and a next step per page and an allocate step for each
// new intermediate table page; a zero page count goes straight to the result.
// The block works on one item at a time and is not ready meanwhile; the next
// item can be taken in the same cycle that the result becomes valid.
// After reset the store is cleared one entry a cycle, all 32768 entries;
// no item is accepted during that time.
// A finished result waits in an output register; while the receiver
// stalls, the block can still take the next item and walk it, and it
// holds that result until the register is free.
module three_level_page_table_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ptw_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ptw_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptw_pkg::PADDR_W-1:0]   paddr,
	input  logic [ptw_pkg::PDATA_W-1:0]   pwdata,
	output logic [ptw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [ptw_pkg::PPN_W-1:0]   base_q;
	logic                        reg_hit;
	ptw_pkg::mem_req_t           mem_req;
	logic [ptw_pkg::ENTRY_W-1:0] mem_rdata;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ptw_pkg::PADDR_W-1:3] == ptw_pkg::REG_TABLE_BASE);
	assign prdata  = reg_hit ? ptw_pkg::PDATA_W'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			base_q <= pwdata[ptw_pkg::PPN_W-1:0];
		end
	end

	ptw_ram #(
		.WIDTH (ptw_pkg::ENTRY_W),
		.DEPTH (ptw_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	ptw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.base      (base_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("walker still ready after taking an item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ptw_pkg::ST_NOPAGES)
		else $error("result status out of range");

	a_leaf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.leaf_entry == '0 || out_data.leaf_entry[0]))
		else $error("non-zero leaf entry without its valid bit");
`endif

endmodule
